### rtl/vpa_pkg.sv
// Shared widths, constants and pipeline stage map for the Voigt profile core.
`timescale 1ns / 1ps

package vpa_pkg;

  // Field widths.
  localparam int unsigned XW  = 24;
  localparam int unsigned AW  = 24;
  localparam int unsigned HW  = 32;
  localparam int unsigned X2W = 47;

  // Fractional divider: 30 quotient bits, two per stage.
  localparam int unsigned DivQW     = 30;
  localparam int unsigned DivStepW  = 2;
  localparam int unsigned DivStages = DivQW / DivStepW;
  localparam int unsigned DenW      = 48;
  localparam int unsigned RemW      = DenW + 1;

  // Region bounds and divider operands.
  localparam logic [X2W-1:0]  K0855    = 47'd3672197038;
  localparam logic [X2W-1:0]  K342     = 47'd14688788152;
  localparam logic [DenW-1:0] UNum     = 48'd1409286144;   // 21 * 2^26
  localparam logic [DivQW:0]  VOne     = 31'd16777216;     // 1.0 in Q.24
  localparam logic [DenW-1:0] WOne     = 48'h0001_0000_0000;

  // Polynomial in c, Horner form in signed Q.28.
  localparam int unsigned HornSteps = 4;
  localparam int unsigned SW        = 35;
  localparam int unsigned SMagW     = 34;
  localparam logic signed [SW-1:0] HornInit = 35'sd1523102777;
  localparam logic signed [SW-1:0] HornAdd [HornSteps] = '{
    -35'sd2471485243, 35'sd1186753151, 35'sd29984240, 35'sd0
  };

  // Lorentz term widths and scale.
  localparam int unsigned PicW = 30;
  localparam int unsigned T1W  = 31;
  localparam int unsigned T2W  = 33;
  localparam int unsigned LorW = 40;
  localparam logic [31:0] InvSqpi = 32'd2423170541;

  // Exponential.
  localparam logic [26:0]     Log2e    = 27'd96817625;
  localparam logic [31:0]     Ln2      = 32'd2977044472;
  localparam logic [X2W-1:0]  ExpLimit = 47'd103079215104;  // 24 * 2^32
  localparam logic [32:0]     ExpOne   = 33'h1_0000_0000;
  localparam int unsigned     ExpTerms = 13;
  localparam int unsigned     RecipSh  = 36;
  localparam int unsigned     RecipW   = 37;
  // ceil(2^36 / k) for k = 1 .. 13, exact quotient for any 32-bit dividend.
  localparam logic [RecipW-1:0] ExpRecip [ExpTerms] = '{
    37'd68719476736, 37'd34359738368, 37'd22906492246, 37'd17179869184,
    37'd13743895348, 37'd11453246123, 37'd9817068106,  37'd8589934592,
    37'd7635497416,  37'd6871947674,  37'd6247225158,  37'd5726623062,
    37'd5286113596
  };

  // Stage map; stage 0 holds x^2.
  localparam int unsigned DivLat  = DivStages;
  localparam int unsigned HornLat = 2 * HornSteps;
  localparam int unsigned ExpLat  = 2 * ExpTerms + 3;
  localparam int unsigned WEnd    = 2 * DivLat;
  localparam int unsigned PicAt   = DivLat + HornLat;
  localparam int unsigned LorAt   = WEnd + 3;
  localparam int unsigned OutAt   = LorAt + 1;

  // Delay line depths.
  localparam int unsigned XDly    = DivLat;
  localparam int unsigned PicDly  = WEnd + 1 - PicAt;
  localparam int unsigned ADly    = WEnd;
  localparam int unsigned GDly    = LorAt - ExpLat;
  localparam int unsigned FlagDly = LorAt;

endpackage

### rtl/voigt_profile_approximation_core.sv
// Top level of the Voigt-Hjerting profile core, Tasitsiomi approximation.
`timescale 1ns / 1ps

// Takes one frequency point (x in signed Q8.16, a in unsigned Q0.24) per clock and
// returns H(a,x) in unsigned Q1.31, saturated at all ones. Results leave in request
// order; the depth is set by two 15-stage radix-4 dividers in series (the ratio c
// and 21/x^2 side by side, then the 1/(x^2+1) scaling), which the 29-stage
// exponential runs alongside. The whole pipeline advances together and holds while
// a finished result waits at the output, so a sustained rate of one point per cycle
// is kept whenever the consumer keeps up.
module voigt_profile_approximation_core import vpa_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic signed [XW-1:0] offset_x_i,
  input  logic        [AW-1:0] damping_a_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic        [HW-1:0] profile_h_o
);

  logic           adv;
  logic [OutAt:0] vld_q;

  // The pipeline moves whenever the output register is free or being drained.
  assign adv        = !vld_q[OutAt] || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[OutAt-1:0], in_valid_i};
    end
  end

  // Stage 0: magnitude of x and its square.
  logic [XW-1:0]   raw;
  logic [XW-1:0]   mag;
  logic [2*XW-1:0] sq;
  logic [X2W-1:0]  x2_q;
  logic [AW-1:0]   a_q;

  assign raw = offset_x_i;
  assign mag = raw[XW-1] ? (~raw + 1'b1) : raw;
  assign sq  = mag * mag;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x2_q <= sq[X2W-1:0];
      a_q  <= damping_a_i;
    end
  end

  // Side data delay lines.
  logic [X2W-1:0] x2d_q [XDly];
  logic [AW-1:0]  ad_q  [ADly];
  logic           fd_q  [FlagDly];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x2d_q[0] <= x2_q;
      ad_q[0]  <= a_q;
      fd_q[0]  <= (x2_q >= K0855);
      for (int i = 1; i < XDly; i++) x2d_q[i] <= x2d_q[i-1];
      for (int i = 1; i < ADly; i++) ad_q[i] <= ad_q[i-1];
      for (int i = 1; i < FlagDly; i++) fd_q[i] <= fd_q[i-1];
    end
  end

  // Ratio c and 21/x^2 in parallel.
  logic [DivQW-1:0] c_quo;
  logic [DivQW-1:0] u_quo;
  logic [DivQW-1:0] w_quo;
  logic [DivQW:0]   v;

  vpa_fdiv u_cdiv (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (DenW'(x2_q - K0855)),
    .den_i (DenW'(x2_q) + DenW'(K342)),
    .quo_o (c_quo)
  );

  vpa_fdiv u_udiv (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (UNum),
    .den_i (DenW'(x2_q)),
    .quo_o (u_quo)
  );

  // w = (1 + 21/x^2) / (x^2 + 1) in Q.26.
  assign v = {1'b0, u_quo} + VOne;

  vpa_fdiv u_wdiv (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (DenW'({v, 4'b0000})),
    .den_i (DenW'(x2d_q[XDly-1]) + WOne),
    .quo_o (w_quo)
  );

  // Polynomial in c by Horner, multiply then round-and-add per step.
  logic [63:0]           hprod_q [HornSteps];
  logic                  hneg_q  [HornSteps];
  logic [DivQW-1:0]      hca_q   [HornSteps];
  logic signed [SW-1:0]  hs_q    [HornSteps];
  logic [DivQW-1:0]      hcb_q   [HornSteps-1];

  for (genvar j = 0; j < HornSteps; j++) begin : g_horn
    logic signed [SW-1:0] s_in;
    logic [DivQW-1:0]     c_in;
    logic [SW-1:0]        sabs;
    logic [64:0]          rsum;
    logic signed [SW-1:0] rnd;
    logic signed [SW-1:0] sv;

    if (j == 0) begin : g_first
      assign s_in = HornInit;
      assign c_in = c_quo;
    end else begin : g_next
      assign s_in = hs_q[j-1];
      assign c_in = hcb_q[j-1];
    end

    assign sabs = s_in[SW-1] ? SW'(-s_in) : SW'(s_in);
    assign rsum = {1'b0, hprod_q[j]} + 65'(64'd1 << 29);
    assign rnd  = rsum[64:30];
    assign sv   = hneg_q[j] ? -rnd : rnd;

    always_ff @(posedge clk_i) begin
      if (adv) begin
        hprod_q[j] <= sabs[SMagW-1:0] * c_in;
        hneg_q[j]  <= s_in[SW-1];
        hca_q[j]   <= c_in;
        hs_q[j]    <= sv + HornAdd[j];
      end
    end

    if (j < HornSteps - 1) begin : g_ccarry
      always_ff @(posedge clk_i) begin
        if (adv) begin
          hcb_q[j] <= hca_q[j];
        end
      end
    end
  end

  // A negative polynomial counts as zero.
  logic [PicW-1:0] pic;
  logic [PicW-1:0] picd_q [PicDly];

  assign pic = hs_q[HornSteps-1][SW-1] ? '0 : hs_q[HornSteps-1][PicW-1:0];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      picd_q[0] <= pic;
      for (int i = 1; i < PicDly; i++) picd_q[i] <= picd_q[i-1];
    end
  end

  // Exponential term.
  logic [HW-1:0] gauss;
  logic [HW-1:0] gd_q [GDly];

  vpa_gauss u_gauss (
    .clk_i   (clk_i),
    .en_i    (adv),
    .x2_i    (x2_q),
    .gauss_o (gauss)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      gd_q[0] <= gauss;
      for (int i = 1; i < GDly; i++) gd_q[i] <= gd_q[i-1];
    end
  end

  // Lorentz term: w * a, times the polynomial, times sqrt(pi)/pi.
  logic [54:0]       t1sum;
  logic [60:0]       t2sum;
  logic [66:0]       lsum;
  logic [T1W-1:0]    t1_q;
  logic [T2W-1:0]    t2_q;
  logic [LorW-1:0]   lor_q;

  assign t1sum = (w_quo * ad_q[ADly-1]) + 55'(64'd1 << 23);
  assign t2sum = (t1_q * picd_q[PicDly-1]) + 61'(64'd1 << 27);
  assign lsum  = (t2_q * InvSqpi) + 67'(64'd1 << 26);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      t1_q  <= t1sum[54:24];
      t2_q  <= t2sum[60:28];
      lor_q <= lsum[66:27];
    end
  end

  // Sum with saturation; the centre region has no Lorentz term.
  logic [LorW:0]  hsum;
  logic [HW-1:0]  profile_h_q;

  assign hsum = (fd_q[FlagDly-1] ? {1'b0, lor_q} : '0) + (LorW+1)'(gd_q[GDly-1]);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      profile_h_q <= (hsum[LorW:HW] != '0) ? '1 : hsum[HW-1:0];
    end
  end

  assign out_valid_o = vld_q[OutAt];
  assign profile_h_o = profile_h_q;

  // Back pressure comes only from a result held at the output.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without a held result");

  // A stalled pipeline keeps every valid bit.
  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q))
    else $error("valid bits moved during a stall");

  // The exponential never exceeds one.
  a_gauss_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[ExpLat] |-> (gauss <= 32'h8000_0000))
    else $error("exponential term above one");

  // In the centre region the result is the exponential term alone.
  a_centre: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[LorAt] && !fd_q[FlagDly-1] && adv) |=> (profile_h_o == $past(gd_q[GDly-1])))
    else $error("centre region result differs from exponential term");

endmodule

### rtl/vpa_fdiv.sv
// Pipelined restoring divider giving floor(num * 2^30 / den), two bits per stage.
`timescale 1ns / 1ps

module vpa_fdiv import vpa_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [DenW-1:0]  num_i,
  input  logic [DenW-1:0]  den_i,
  output logic [DivQW-1:0] quo_o
);

  logic [RemW-1:0]  rem_q [DivStages-1];
  logic [DenW-1:0]  den_q [DivStages-1];
  logic [DivQW-1:0] quo_q [DivStages];

  for (genvar s = 0; s < DivStages; s++) begin : g_stage
    logic [RemW-1:0]  rem_in;
    logic [DenW-1:0]  den_in;
    logic [DivQW-1:0] quo_in;
    logic [RemW-1:0]  rem_d;
    logic [DivQW-1:0] quo_d;

    if (s == 0) begin : g_first
      assign rem_in = {1'b0, num_i};
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    // Shift in a zero, subtract the divisor where it fits, one quotient bit each.
    always_comb begin
      rem_d = rem_in;
      quo_d = quo_in;
      for (int b = 0; b < DivStepW; b++) begin
        rem_d = {rem_d[RemW-2:0], 1'b0};
        quo_d = {quo_d[DivQW-2:0], 1'b0};
        if (rem_d >= {1'b0, den_in}) begin
          rem_d    = rem_d - {1'b0, den_in};
          quo_d[0] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[s] <= quo_d;
      end
    end

    // The last stage needs neither remainder nor divisor.
    if (s < DivStages - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[s] <= rem_d;
          den_q[s] <= den_in;
        end
      end
    end
  end

  assign quo_o = quo_q[DivStages-1];

endmodule

### rtl/vpa_gauss.sv
// Pipelined exp(-x^2) in Q1.31 through a power of two and a Taylor series.
`timescale 1ns / 1ps

module vpa_gauss import vpa_pkg::*; (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [X2W-1:0] x2_i,
  output logic [HW-1:0]  gauss_o
);

  logic [63:0] zprod;
  logic [5:0]  n1_q, n2_q;
  logic [31:0] f1_q, t2_q;
  logic        far1_q, far2_q;
  logic [63:0] tprod;

  // Split x^2 * log2(e) into an integer and a fractional part.
  assign zprod = x2_i[36:0] * Log2e;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n1_q   <= zprod[63:58];
      f1_q   <= zprod[57:26];
      far1_q <= (x2_i >= ExpLimit);
    end
  end

  // Fraction back to natural units: t = f * ln2.
  assign tprod = f1_q * Ln2;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t2_q   <= tprod[63:32];
      n2_q   <= n1_q;
      far2_q <= far1_q;
    end
  end

  logic [32:0] hi_q [ExpTerms];
  logic [31:0] ta_q [ExpTerms];
  logic [5:0]  na_q [ExpTerms];
  logic        fa_q [ExpTerms];
  logic [32:0] p_q  [ExpTerms];
  logic [31:0] tb_q [ExpTerms-1];
  logic [5:0]  nb_q [ExpTerms];
  logic        fb_q [ExpTerms];

  // Horner over the Taylor terms, k from 13 down to 1, two stages per term.
  for (genvar j = 0; j < ExpTerms; j++) begin : g_term
    logic [31:0] t_in;
    logic [32:0] p_in;
    logic [5:0]  n_in;
    logic        f_in;
    logic [64:0] prod;
    logic [69:0] qprod;

    if (j == 0) begin : g_first
      assign t_in = t2_q;
      assign p_in = ExpOne;
      assign n_in = n2_q;
      assign f_in = far2_q;
    end else begin : g_next
      assign t_in = tb_q[j-1];
      assign p_in = p_q[j-1];
      assign n_in = nb_q[j-1];
      assign f_in = fb_q[j-1];
    end

    assign prod  = t_in * p_in;
    assign qprod = hi_q[j] * ExpRecip[ExpTerms-1-j];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        hi_q[j] <= prod[64:32];
        ta_q[j] <= t_in;
        na_q[j] <= n_in;
        fa_q[j] <= f_in;
        p_q[j]  <= ExpOne - qprod[RecipSh+32:RecipSh];
        nb_q[j] <= na_q[j];
        fb_q[j] <= fa_q[j];
      end
    end

    if (j < ExpTerms - 1) begin : g_tcarry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          tb_q[j] <= ta_q[j];
        end
      end
    end
  end

  logic [35:0] gsum;
  logic [35:0] gshift;
  logic [HW-1:0] gauss_q;

  // Scale by 2^-(n+1) with rounding; the far wing underflows to zero.
  assign gsum   = {3'b000, p_q[ExpTerms-1]} + (36'd1 << nb_q[ExpTerms-1]);
  assign gshift = gsum >> (nb_q[ExpTerms-1] + 7'd1);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      gauss_q <= fb_q[ExpTerms-1] ? '0 : gshift[HW-1:0];
    end
  end

  assign gauss_o = gauss_q;

endmodule

### bench/voigt_profile_approximation_core_tb.sv
// Self-checking testbench for the Voigt-Hjerting profile core.
`timescale 1ns / 1ps

module voigt_profile_approximation_core_tb import vpa_pkg::*;;

  localparam int unsigned Latency   = 34;
  localparam int unsigned IdleLimit = 20000;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic signed [XW-1:0] offset_x_i;
  logic        [AW-1:0] damping_a_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic        [HW-1:0] profile_h_o;

  // Expected profile values, oldest first.
  logic [HW-1:0] profile_queue[$];
  int            mismatch_count;
  int            idle_cycles;

  voigt_profile_approximation_core dut (.*);

  // Clock generation.
  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Rounded product of a signed Horner value and c, shifted right by 30.
  function automatic longint horner_mul(longint s, longint unsigned c);
    longint unsigned mag;
    longint unsigned prod;
    mag  = (s < 0) ? longint'(-s) : longint'(s);
    prod = (mag * c + (64'd1 << 29)) >> 30;
    return (s < 0) ? -longint'(prod) : longint'(prod);
  endfunction

  // exp(-x^2) term in Q1.31.
  function automatic longint unsigned gauss_term(longint unsigned x2);
    longint unsigned z;
    longint unsigned f;
    longint unsigned t;
    longint unsigned p;
    int unsigned     n;
    if (x2 >= (64'd24 << 32)) return 0;
    z = (x2 * 64'd96817625) >> 26;
    n = int'(z >> 32);
    f = z & 64'hFFFF_FFFF;
    t = (f * 64'd2977044472) >> 32;
    p = 64'h1_0000_0000;
    for (int k = 13; k >= 1; k--) begin
      p = 64'h1_0000_0000 - (((t * p) / k) >> 32);
    end
    return (p + (64'd1 << n)) >> (n + 1);
  endfunction

  // Lorentz wing term in Q1.31.
  function automatic longint unsigned lorentz_term(longint unsigned x2, longint unsigned a);
    longint unsigned rem;
    longint unsigned den;
    longint unsigned c;
    longint unsigned pic;
    longint unsigned u;
    longint unsigned w;
    longint unsigned t1;
    longint unsigned t2;
    longint          s;
    if (x2 < 64'd3672197038) return 0;
    // Long division for c in Q0.30.
    rem = x2 - 64'd3672197038;
    den = x2 + 64'd14688788152;
    c   = 0;
    for (int i = 0; i < 30; i++) begin
      rem = rem << 1;
      c   = c << 1;
      if (rem >= den) begin
        rem = rem - den;
        c   = c | 64'd1;
      end
    end
    s   = 64'sd1523102777;
    s   = horner_mul(s, c) - 64'sd2471485243;
    s   = horner_mul(s, c) + 64'sd1186753151;
    s   = horner_mul(s, c) + 64'sd29984240;
    s   = horner_mul(s, c);
    pic = (s < 0) ? 64'd0 : longint'(s);
    u   = (64'd21 << 56) / x2;
    w   = (((64'd1 << 24) + u) << 34) / (x2 + 64'h1_0000_0000);
    t1  = (w * a + (64'd1 << 23)) >> 24;
    t2  = (t1 * pic + (64'd1 << 27)) >> 28;
    return (t2 * 64'd2423170541 + (64'd1 << 26)) >> 27;
  endfunction

  function automatic logic [HW-1:0] voigt_value(logic [XW-1:0] x, logic [AW-1:0] a);
    longint unsigned mag;
    longint unsigned x2;
    longint unsigned h;
    mag = x[XW-1] ? (64'h100_0000 - longint'(x)) : longint'(x);
    x2  = mag * mag;
    h   = lorentz_term(x2, longint'(a)) + gauss_term(x2);
    return (h > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : h[31:0];
  endfunction

  // Send one request after a random gap and wait until it is taken. The task
  // returns at the accepting edge; valid drops at the next falling edge only
  // when a gap or a pause follows.
  task automatic send_point(logic [XW-1:0] x, logic [AW-1:0] a, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 18);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    offset_x_i  <= x;
    damping_a_i <= a;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    profile_queue.push_back(voigt_value(x, a));
  endtask

  // Drop the input valid after the last accepted request.
  task automatic idle_input();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // Receiver: random stalls, compare each result with the oldest expectation.
  initial begin
    int stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      if (profile_queue.size() == 0) begin
        $error("profile_h: result 0x%08h with no request waiting", profile_h_o);
        mismatch_count++;
      end else begin
        logic [HW-1:0] expected;
        expected = profile_queue.pop_front();
        if (profile_h_o !== expected) begin
          $error("profile_h: expected 0x%08h, actual 0x%08h", expected, profile_h_o);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no accepted handshake.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Centre, far wing, both region boundaries, field extremes and the most negative offset.
  task automatic test_directed();
    logic [XW-1:0] xs[12];
    xs = '{24'h000000, 24'h000001, 24'hFFFFFF, 24'h7FFFFF, 24'h800000, 24'h00EC00,
           24'h00ED00, 24'h010000, 24'h04E600, 24'h04E700, 24'h0A0000, 24'hF60000};
    foreach (xs[i]) begin
      send_point(xs[i], 24'hFFFFFF);
      send_point(xs[i], (i % 2) ? 24'h000000 : 24'h000001);
    end
  endtask

  // Pause until the pipeline has drained, then resume.
  task automatic test_drain_pause();
    send_point(24'h018000, 24'h123456);
    idle_input();
    wait (profile_queue.size() == 0);
    repeat (Latency + 4) @(negedge clk_i);
    send_point(24'hFE8000, 24'hABCDEF);
  endtask

  // Random points, mostly in the interesting range near the line core.
  task automatic test_random_points();
    logic [XW-1:0] x;
    bit            burst;
    for (int i = 0; i < 400; i++) begin
      case ($urandom_range(0, 3))
        0:       x = 24'($urandom());
        1:       x = 24'($signed($urandom_range(0, 24'h0A0000)) - 32'sh050000);
        2:       x = 24'($signed($urandom_range(0, 24'h600000)) - 32'sh300000);
        default: x = 24'($signed($urandom_range(0, 24'h040000)) - 32'sh020000);
      endcase
      burst = (i % 80) < 20;
      send_point(x, 24'($urandom()), burst);
    end
  endtask

  initial begin
    mismatch_count = 0;
    idle_cycles    = 0;
    in_valid_i     = 1'b0;
    offset_x_i     = '0;
    damping_a_i    = '0;
    rst_ni         = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_drain_pause();
    test_random_points();
    idle_input();
    wait (profile_queue.size() == 0);
    repeat (Latency + 10) @(negedge clk_i);
    if (mismatch_count == 0 && profile_queue.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
